/* rtl/lgge_pkg.sv */
// Shared types and constants for the life grid generation engine.
package lgge_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE   = 2'd2;

  // Configuration values after reset.
  localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CFG_DATA_W-1:0] COLS_RESET = 7'd64;
  localparam logic                  WRAP_RESET = 1'b1;

  // B3/S23 neighbor counts.
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] row_index;
    logic [5:0] col_index;
    logic       write_value;
  } in_item_t;

  typedef struct packed {
    logic       read_value;
    logic [1:0] op_done;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL_RD,
    S_CELL_WB,
    S_ADV_RD,
    S_ADV_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic cell_rd;
    logic cell_wb;
    logic adv_rd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rd_last;
    logic adv_done;
  } dp_stat_t;

endpackage

/* rtl/life_grid_generation_engine.sv */
// Top level of the life grid engine: Conway B3/S23 on a stored cell grid.
//
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_data (in_item_t: opcode, row, column, value)
// out_      output     out_valid / out_ready  out_data (out_item_t: read value, opcode echo)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// After reset a clearing pass writes every grid row to dead, one row per cycle; no input
// transaction is taken during it, configuration writes are.
// A cell write or read steps through S_CELL_RD, S_CELL_WB and S_DONE, and its result is
// registered on leaving S_DONE, before the next transaction can be accepted.
// An advance covers the effective row count (rows_in_use, with zero counted as one and
// values above MAX_ROWS as MAX_ROWS): the single memory read port streams one row per
// cycle into a three-row window, and each new row is written back once the row below it
// has entered the window.
// A stalled output holds the result register; the next input transaction is still taken
// and waits for the output register before its own result is loaded.
module life_grid_generation_engine
  import lgge_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Registers may be written at any time the block is idle, so the port never stalls.
  assign cfg_ready = 1'b1;

  // The controller owns both handshakes and steps the datapath through each operation.
  lgge_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the grid, the configuration and the result register.
  lgge_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // No input transaction can be taken while the clearing pass runs.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_ready)
    else $error("input accepted during clearing pass");

  // The controller issues at most one datapath command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr, cmd.load, cmd.cell_rd, cmd.cell_wb, cmd.adv_rd, cmd.out_load}))
    else $error("conflicting datapath commands");

  // Loading the result register always presents a valid result next cycle.
  a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result loaded but not presented");

  // A result is only loaded when the previous one is gone or leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

endmodule

/* rtl/lgge_ctrl.sv */
// Sequencer for the life grid engine: handshakes, clear pass and operation steps.
module lgge_ctrl
  import lgge_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_op)
            OP_WRITE, OP_READ: state_nxt = S_CELL_RD;
            OP_ADVANCE:        state_nxt = S_ADV_RD;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end
      S_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = S_CELL_WB;
      end
      S_CELL_WB: begin
        cmd.cell_wb = 1'b1;
        state_nxt   = S_DONE;
      end
      S_ADV_RD: begin
        cmd.adv_rd = 1'b1;
        if (stat.rd_last) state_nxt = S_ADV_DRAIN;
      end
      S_ADV_DRAIN: begin
        if (stat.adv_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/lgge_dp.sv */
// Datapath of the life grid engine: grid memory, row window, rule logic and registers.
module lgge_dp
  import lgge_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  output out_item_t             out_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat
);

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] cfg_rows_r, cfg_cols_r;
  logic                  cfg_wrap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= ROWS_RESET;
      cfg_cols_r <= COLS_RESET;
      cfg_wrap_r <= WRAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS_IN_USE: cfg_rows_r <= cfg_data;
        CFG_COLS_IN_USE: cfg_cols_r <= cfg_data;
        CFG_WRAP_MODE:   cfg_wrap_r <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // Effective region size: zero acts as one, oversize saturates.
  logic [RCW-1:0] rows_eff, rows_m1;
  logic [CCW-1:0] cols_eff, cols_m1;

  always_comb begin
    priority if (cfg_rows_r == '0)          rows_eff = RCW'(1);
    else if (32'(cfg_rows_r) > MAX_ROWS)    rows_eff = RCW'(MAX_ROWS);
    else                                    rows_eff = RCW'(cfg_rows_r);
    priority if (cfg_cols_r == '0)          cols_eff = CCW'(1);
    else if (32'(cfg_cols_r) > MAX_COLS)    cols_eff = CCW'(MAX_COLS);
    else                                    cols_eff = CCW'(cfg_cols_r);
    rows_m1 = rows_eff - RCW'(1);
    cols_m1 = cols_eff - CCW'(1);
  end

  // Item and per-operation settings, captured when a transaction is taken.
  in_item_t       item_r;
  logic           inside_r;
  logic [RCW-1:0] nr_r;
  logic [RAW-1:0] nrm1_r;
  logic [CAW-1:0] ncm1_r;
  logic           wrap_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r   <= in_data;
      inside_r <= (32'(in_data.row_index) < MAX_ROWS) && (32'(in_data.col_index) < MAX_COLS);
      nr_r     <= rows_eff;
      nrm1_r   <= rows_m1[RAW-1:0];
      ncm1_r   <= cols_m1[CAW-1:0];
      wrap_r   <= cfg_wrap_r;
    end
  end

  logic [RAW-1:0] cell_addr;
  logic [CAW-1:0] col_addr;
  assign cell_addr = RAW'(item_r.row_index);
  assign col_addr  = CAW'(item_r.col_index);

  // Grid memory: one read port with registered data, one write port.
  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data_r;
  logic                rd_en, we;
  logic [RAW-1:0]      rd_addr, wr_addr, adv_addr;
  logic [MAX_COLS-1:0] wr_data, cell_row, new_row;

  // Advance sequencing registers.
  logic [RCW-1:0] rd_cnt_r, rd_cnt_m1;
  logic           rd_vld_r, rd_first_r, rd_row0_r, rd_lst_r, extra_r;
  logic [1:0]     push_cnt_r;
  logic           wr_vld_r;
  logic [RAW-1:0] wr_row_r;
  logic [RAW-1:0] clr_cnt_r;
  logic [MAX_COLS-1:0] prev_r, cur_r, nxt_r, row0_r, push_data;
  logic           push;

  // The first read fetches the last row as the upper neighbor of row zero.
  assign rd_cnt_m1 = rd_cnt_r - RCW'(1);
  assign adv_addr  = (rd_cnt_r == '0) ? nrm1_r : rd_cnt_m1[RAW-1:0];
  assign rd_en     = cmd.adv_rd | cmd.cell_rd;
  assign rd_addr   = cmd.adv_rd ? adv_addr : cell_addr;

  always_comb begin
    cell_row           = rd_data_r;
    cell_row[col_addr] = item_r.write_value;
    we      = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = '0;
    priority if (cmd.clr) begin
      we = 1'b1;
    end else if (wr_vld_r) begin
      we      = 1'b1;
      wr_addr = wr_row_r;
      wr_data = new_row;
    end else if (cmd.cell_wb && (item_r.opcode == OP_WRITE) && inside_r) begin
      we      = 1'b1;
      wr_addr = cell_addr;
      wr_data = cell_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= grid_mem[rd_addr];
    if (we) grid_mem[wr_addr] <= wr_data;
  end

  // Row window: rows shift in from the memory, plus one closing row after the last read.
  assign push = rd_vld_r | extra_r;

  always_comb begin
    priority if (extra_r)             push_data = wrap_r ? row0_r : '0;
    else if (rd_first_r && !wrap_r)   push_data = '0;
    else                              push_data = rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      prev_r <= cur_r;
      cur_r  <= nxt_r;
      nxt_r  <= push_data;
    end
    if (rd_vld_r && rd_row0_r) row0_r <= rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r   <= '0;
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
      rd_row0_r  <= 1'b0;
      rd_lst_r   <= 1'b0;
      extra_r    <= 1'b0;
      push_cnt_r <= '0;
      wr_vld_r   <= 1'b0;
      wr_row_r   <= '0;
      clr_cnt_r  <= '0;
    end else begin
      rd_vld_r   <= cmd.adv_rd;
      rd_first_r <= cmd.adv_rd && (rd_cnt_r == '0);
      rd_row0_r  <= cmd.adv_rd && (rd_cnt_r == RCW'(1));
      rd_lst_r   <= cmd.adv_rd && stat.rd_last;
      extra_r    <= rd_vld_r && rd_lst_r;
      wr_vld_r   <= push && (push_cnt_r == 2'd2);
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + RAW'(1);
      if (cmd.load) begin
        rd_cnt_r   <= '0;
        push_cnt_r <= '0;
        wr_row_r   <= '0;
      end else begin
        if (cmd.adv_rd) rd_cnt_r <= rd_cnt_r + RCW'(1);
        if (push && (push_cnt_r != 2'd2)) push_cnt_r <= push_cnt_r + 2'd1;
        if (wr_vld_r) wr_row_r <= wr_row_r + RAW'(1);
      end
    end
  end

  // B3/S23 rule for one whole row; columns past the region keep their value.
  for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
    logic       pl, cl, nl, pr, cr, nr;
    logic [3:0] cnt;

    if (j == 0) begin : g_left_edge
      assign pl = wrap_r & prev_r[ncm1_r];
      assign cl = wrap_r & cur_r[ncm1_r];
      assign nl = wrap_r & nxt_r[ncm1_r];
    end else begin : g_left
      assign pl = prev_r[j-1];
      assign cl = cur_r[j-1];
      assign nl = nxt_r[j-1];
    end

    if (j + 1 < MAX_COLS) begin : g_right
      logic is_last;
      assign is_last = (CAW'(j) == ncm1_r);
      assign pr = is_last ? (wrap_r & prev_r[0]) : prev_r[j+1];
      assign cr = is_last ? (wrap_r & cur_r[0])  : cur_r[j+1];
      assign nr = is_last ? (wrap_r & nxt_r[0])  : nxt_r[j+1];
    end else begin : g_right_edge
      assign pr = wrap_r & prev_r[0];
      assign cr = wrap_r & cur_r[0];
      assign nr = wrap_r & nxt_r[0];
    end

    assign cnt = 4'(pl) + 4'(prev_r[j]) + 4'(pr) + 4'(cl) + 4'(cr)
               + 4'(nl) + 4'(nxt_r[j]) + 4'(nr);

    assign new_row[j] = (CAW'(j) <= ncm1_r)
                      ? ((cnt == BIRTH_COUNT) || (cur_r[j] && (cnt == SURVIVE_COUNT)))
                      : cur_r[j];
  end

  // Result register.
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.op_done    <= item_r.opcode;
      out_r.read_value <= (item_r.opcode == OP_READ) && inside_r && rd_data_r[col_addr];
    end
  end

  assign out_data      = out_r;
  assign stat.clr_last = (clr_cnt_r == RAW'(MAX_ROWS - 1));
  assign stat.rd_last  = (rd_cnt_r == nr_r);
  assign stat.adv_done = wr_vld_r && (wr_row_r == nrm1_r);

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the life grid generation engine.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lgge_pkg::*;

  // Opcode that the block ignores without producing a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;

  // Cycles to let pass after the last result before a register write or the end of
  // the run.
  localparam int SETTLE_CYCLES = 100;

  // The watchdog ends the run after this many cycles without any transaction.
  localparam int STALL_LIMIT = 2000;

  localparam int NUM_PHASES = 11;

  // Tracks the cell grid and the configuration as the block should hold them, and
  // keeps the results that the accepted commands are still owed.
  class life_grid_tracker;
    logic [GRID_COLS-1:0] cells [GRID_ROWS];
    logic [CFG_DATA_W-1:0] rows_cfg;
    logic [CFG_DATA_W-1:0] cols_cfg;
    logic wrap_cfg;
    out_item_t owed_results [$];
    int errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      wrap_cfg = WRAP_RESET;
      errors = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ROWS_IN_USE: rows_cfg = data;
        CFG_COLS_IN_USE: cols_cfg = data;
        CFG_WRAP_MODE:   wrap_cfg = data[0];
        default: ;
      endcase
    endfunction

    // Applies one accepted command to the grid and queues the result it owes.
    function void note_command(in_item_t item);
      out_item_t res;
      logic [GRID_COLS-1:0] nxt [GRID_ROWS];
      int nr, nc, cnt, rr, cc;

      res.read_value = 1'b0;
      res.op_done = item.opcode;
      case (op_t'(item.opcode))
        OP_WRITE: cells[item.row_index][item.col_index] = item.write_value;
        OP_READ:  res.read_value = cells[item.row_index][item.col_index];
        OP_ADVANCE: begin
          // A size of zero behaves as one, and anything above the grid saturates.
          nr = (rows_cfg == 0) ? 1 : ((rows_cfg > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg));
          nc = (cols_cfg == 0) ? 1 : ((cols_cfg > GRID_COLS) ? GRID_COLS : int'(cols_cfg));
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              cnt = 0;
              for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                  if (dr == 0 && dc == 0) continue;
                  rr = i + dr;
                  cc = j + dc;
                  if (wrap_cfg) begin
                    // On a toroid of size one or two the same cell may be counted
                    // several times, the cell itself included.
                    rr = (rr + nr) % nr;
                    cc = (cc + nc) % nc;
                  end else if (rr < 0 || rr >= nr || cc < 0 || cc >= nc) begin
                    continue;
                  end
                  cnt += cells[rr][cc];
                end
              end
              nxt[i][j] = (cnt == BIRTH_COUNT) || (cells[i][j] && cnt == SURVIVE_COUNT);
            end
          end
          for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++)
              cells[i][j] = nxt[i][j];
        end
        default: return;
      endcase
      owed_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (owed_results.size() == 0) begin
        $error("result with nothing outstanding: read_value %0d op_done %0d",
               got.read_value, got.op_done);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected %0d, actual %0d", exp.read_value, got.read_value);
        errors++;
      end
      if (got.op_done !== exp.op_done) begin
        $error("op_done: expected %0d, actual %0d", exp.op_done, got.op_done);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // When set, the sender or the receiver runs without any pauses.
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;

  life_grid_tracker tracker;
  int idle_cycles = 0;

  life_grid_generation_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pause lengths: mostly none, often short, now and then a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, int row, int col, logic val);
    in_item_t item;
    item.opcode = op;
    item.row_index = row[5:0];
    item.col_index = col[5:0];
    item.write_value = val;
    return item;
  endfunction

  // The receiver stalls in random stretches unless it has been told to run steady.
  always @(negedge clk) begin : receiver
    int stall_left;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = rx_steady ? 0 : pick_pause();
    end
  end

  // Checks every result transaction and watches for a block that has stopped moving.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        tracker.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Presents one command after an optional gap and holds it until it is taken. The
  // valid stays high afterwards; the next call or end_commands decides its fate.
  task automatic send_command(in_item_t item);
    int gap;
    gap = tx_steady ? 0 : pick_pause();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    tracker.note_command(item);
  endtask

  task automatic end_commands();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Drops the input valid and waits until every owed result has come back.
  task automatic drain_results();
    end_commands();
    while (tracker.outstanding() != 0) @(negedge clk);
  endtask

  // Writes one configuration register. Like send_command, the valid is left high.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(idx, data);
  endtask

  // Brings the block to rest, then loads a full new setting. The unused register
  // index is written too; it must not disturb anything.
  task automatic configure(int rows, int cols, logic wrap);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_cfg(CFG_ROWS_IN_USE, rows[CFG_DATA_W-1:0]);
    write_cfg(CFG_COLS_IN_USE, cols[CFG_DATA_W-1:0]);
    write_cfg(CFG_WRAP_MODE, {{(CFG_DATA_W-1){1'b1}}, wrap});
    write_cfg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 127)));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int ph_rows  [NUM_PHASES] = '{64, 8, 1, 2, 0, 127, 2, 5, 0, 64, 100};
    int ph_cols  [NUM_PHASES] = '{64, 8, 1, 2, 0, 127, 5, 3, 0, 64, 1};
    int ph_wrap  [NUM_PHASES] = '{1, 0, 1, 1, 1, 0, 1, 0, 0, 0, 1};
    int ph_items [NUM_PHASES] = '{100, 110, 40, 50, 30, 60, 50, 50, 60, 60, 30};
    int rows, cols, nr, nc, anchor_r, anchor_c, r;
    logic wrap;
    in_item_t item;

    tracker = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset setting, a 64 by 64 toroid. The four corners form
    // a block that only exists across the wrapped edges, so it must stay stable.
    send_command(make_item(OP_WRITE, 0, 0, 1'b1));
    send_command(make_item(OP_WRITE, 0, 63, 1'b1));
    send_command(make_item(OP_WRITE, 63, 0, 1'b1));
    send_command(make_item(OP_WRITE, 63, 63, 1'b1));
    send_command(make_item(OP_READ, 63, 63, 1'b0));
    // A blinker in the middle flips between horizontal and vertical.
    send_command(make_item(OP_WRITE, 31, 30, 1'b1));
    send_command(make_item(OP_WRITE, 31, 31, 1'b1));
    send_command(make_item(OP_WRITE, 31, 32, 1'b1));
    send_command(make_item(OP_ADVANCE, 0, 0, 1'b0));
    send_command(make_item(OP_READ, 0, 0, 1'b0));
    send_command(make_item(OP_READ, 63, 0, 1'b0));
    send_command(make_item(OP_READ, 30, 31, 1'b0));
    send_command(make_item(OP_READ, 31, 30, 1'b0));
    // The unused opcode, with every other field bit set, gives no result.
    send_command(make_item(OP_UNUSED, 63, 63, 1'b1));
    // Killing one corner cell leaves three cells that bring it back to life.
    send_command(make_item(OP_WRITE, 0, 0, 1'b0));
    send_command(make_item(OP_ADVANCE, 63, 63, 1'b1));
    send_command(make_item(OP_READ, 0, 0, 1'b0));
    send_command(make_item(OP_READ, 31, 31, 1'b0));
    send_command(make_item(OP_WRITE, 42, 21, 1'b1));
    send_command(make_item(OP_READ, 42, 21, 1'b1));
    send_command(make_item(OP_WRITE, 21, 42, 1'b0));
    send_command(make_item(OP_READ, 21, 42, 1'b0));
    // The sender holds off here until every result is back.
    drain_results();

    // Random part, one phase per setting. Most traffic lands in a small window of
    // the in-use region so that patterns build up; the window may straddle the
    // wrapped edges. The rest reaches anywhere in the grid.
    for (int p = 0; p < NUM_PHASES; p++) begin
      rows = ph_rows[p];
      cols = ph_cols[p];
      wrap = ph_wrap[p][0];
      if (p == 8) begin
        rows = $urandom_range(1, 64);
        cols = $urandom_range(1, 64);
        wrap = 1'($urandom_range(0, 1));
      end
      configure(rows, cols, wrap);
      tx_steady <= ($urandom_range(0, 4) == 0);
      rx_steady <= ($urandom_range(0, 4) == 0);
      nr = (rows == 0) ? 1 : ((rows > GRID_ROWS) ? GRID_ROWS : rows);
      nc = (cols == 0) ? 1 : ((cols > GRID_COLS) ? GRID_COLS : cols);
      anchor_r = $urandom_range(0, nr - 1);
      anchor_c = $urandom_range(0, nc - 1);

      for (int n = 0; n < ph_items[p]; n++) begin
        item = make_item(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                         1'($urandom_range(0, 1)));
        r = $urandom_range(0, 99);
        if (r < 45) item.opcode = OP_WRITE;
        else if (r < 70) item.opcode = OP_READ;
        else if (r < 94) item.opcode = OP_ADVANCE;
        else item.opcode = OP_UNUSED;
        if ((item.opcode == OP_WRITE || item.opcode == OP_READ)
            && $urandom_range(0, 99) < 75) begin
          item.row_index = 6'((anchor_r + $urandom_range(0, 5)) % nr);
          item.col_index = 6'((anchor_c + $urandom_range(0, 5)) % nc);
        end
        if (item.opcode == OP_WRITE)
          item.write_value = ($urandom_range(0, 99) < 60);
        send_command(item);
        // Now and then the sender also waits for the block to catch up mid-phase.
        if ($urandom_range(0, 99) < 2)
          drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
